### rtl/rgba_conv3x3_clamped_edges_top_macros.svh
// Assertion helpers for the convolution block.
`ifndef RGBA_CONV3X3_CLAMPED_EDGES_TOP_MACROS_SVH
`define RGBA_CONV3X3_CLAMPED_EDGES_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RGBC_ASSERT_SAME(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);
`define RGBC_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);
`else
`define RGBC_ASSERT_SAME(lbl, ant, cons, msg)
`define RGBC_ASSERT_NEXT(lbl, ant, cons, msg)
`endif
`endif

### rtl/rgbc_pkg.sv
package rgbc_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int COEF_BITS_DEF  = 8;

    localparam int PIX_W = 32;

    typedef logic [PIX_W-1:0] pixel_t;
    // one window column, index 0 is the oldest row
    typedef logic [2:0][PIX_W-1:0] col_t;

    localparam logic [2:0] REG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_KTOP    = 3'd2;
    localparam logic [2:0] REG_KBOT    = 3'd3;
    localparam logic [2:0] REG_DIVISOR = 3'd4;
    localparam logic [2:0] REG_MASK    = 3'd5;

    localparam logic signed [15:0] DIV_UNITY = 16'sd256;

endpackage

### rtl/rgbc_ram.sv
module rgbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic [AW-1:0]    addr,
    input  logic             we,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

### rtl/rgbc_cell.sv
module rgbc_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          shift,
    input  rgbc_pkg::col_t col_in,
    output rgbc_pkg::col_t col_out
);

    rgbc_pkg::col_t col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

### rtl/rgbc_div.sv
module rgbc_div #(
    parameter int NW = 31,
    parameter int DW = 17
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   rem_sh;
    logic          fits;

    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    // restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NW-2:0], fits};
            rem_reg <= fits ? DW'(rem_sh - {1'b0, den_reg}) : DW'(rem_sh);
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = num_reg;

endmodule

### rtl/rgba_conv3x3_clamped_edges_top.sv
// 3x3 convolution over an RGBA raster stream with replicated borders.
// s_ channel: one pixel per item in raster order. m_ channel: filtered
// pixels with their coordinates; tlast marks the last result of an input
// item, tuser marks the bottom right pixel of the frame.
// Results trail the input by one row and one column; an input item causes
// 0 to 4 results, the last row and column are flushed as they stream in.
// An input item passes a line buffer read and a window shift; each result
// then takes the multiply-accumulate over the taps, a scale step, the
// bit-serial division when enabled (NW = COEF_BITS + 23 quotient bits), output.
// Only one item is in work at a time; s_tready is high only when idle.
// The window is a chain of three column cells; the two line buffers are
// single-port RAMs read in the cycle before they are written.
// When the receiver stalls, the result is held in the output register and
// no new input is taken. Reset clears counters, window and registers to
// width 1, height 1, zero kernel, divisor 1.0 and all channels passed.
// Config port: APB, 64-bit data, register i at byte address 8*i.
`include "rgba_conv3x3_clamped_edges_top_macros.svh"
module rgba_conv3x3_clamped_edges_top #(
    parameter int MAX_WIDTH  = rgbc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgbc_pkg::MAX_HEIGHT_DEF,
    parameter int COEF_BITS  = rgbc_pkg::COEF_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // red, green, blue, alpha
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // red_out, green_out, blue_out, alpha_out, out_col, out_row
    output logic        m_tlast,  // last_of_run
    output logic        m_tuser   // frame_done
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CB = COEF_BITS;
    localparam int AW = CB + 13;
    localparam int NW = AW + 10;
    localparam int DW = 17;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MAC, ST_SCALE, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg;

    logic [11:0] width_reg, height_reg;
    logic [47:0] ktop_reg;
    logic [23:0] kbot_reg;
    logic signed [15:0] divisor_reg;
    logic [3:0]  mask_reg;

    // config port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= 12'd1;
            height_reg  <= 12'd1;
            ktop_reg    <= '0;
            kbot_reg    <= '0;
            divisor_reg <= rgbc_pkg::DIV_UNITY;
            mask_reg    <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                rgbc_pkg::REG_WIDTH:   width_reg   <= pwdata[11:0];
                rgbc_pkg::REG_HEIGHT:  height_reg  <= pwdata[11:0];
                rgbc_pkg::REG_KTOP:    ktop_reg    <= pwdata[47:0];
                rgbc_pkg::REG_KBOT:    kbot_reg    <= pwdata[23:0];
                rgbc_pkg::REG_DIVISOR: divisor_reg <= pwdata[15:0];
                rgbc_pkg::REG_MASK:    mask_reg    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            rgbc_pkg::REG_WIDTH:   prdata = 64'(width_reg);
            rgbc_pkg::REG_HEIGHT:  prdata = 64'(height_reg);
            rgbc_pkg::REG_KTOP:    prdata = 64'(ktop_reg);
            rgbc_pkg::REG_KBOT:    prdata = 64'(kbot_reg);
            rgbc_pkg::REG_DIVISOR: prdata = 64'(unsigned'(divisor_reg));
            rgbc_pkg::REG_MASK:    prdata = 64'(mask_reg);
            default:               prdata = '0;
        endcase
    end

    // effective geometry, last column and row
    logic [XW-1:0] wm1;
    logic [YW-1:0] hm1;

    always_comb begin
        if (width_reg == 12'd0) begin
            wm1 = '0;
        end else if (32'(width_reg) > MAX_WIDTH) begin
            wm1 = XW'(MAX_WIDTH - 1);
        end else begin
            wm1 = XW'(width_reg - 12'd1);
        end
        if (height_reg == 12'd0) begin
            hm1 = '0;
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            hm1 = YW'(MAX_HEIGHT - 1);
        end else begin
            hm1 = YW'(height_reg - 12'd1);
        end
    end

    // kernel coefficients
    logic signed [CB-1:0] coef [9];

    for (genvar i = 0; i < 9; i++) begin : g_coef
        localparam int SH = ((i < 6) ? i : i - 6) * CB;
        logic [63:0] src;
        assign src = (i < 6) ? 64'(ktop_reg) : 64'(kbot_reg);
        if (SH >= 64) begin : g_zero
            assign coef[i] = '0;
        end else begin : g_take
            assign coef[i] = CB'(src >> SH);
        end
    end

    // position counters
    logic [XW-1:0] col_cnt_reg, c_reg;
    logic [YW-1:0] row_cnt_reg, r_reg;
    logic [XW-1:0] c_now;
    logic [YW-1:0] r_now;
    rgbc_pkg::pixel_t pix_reg;

    assign c_now = (col_cnt_reg < wm1) ? col_cnt_reg : wm1;
    assign r_now = (row_cnt_reg < hm1) ? row_cnt_reg : hm1;

    logic in_acc;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // line buffers
    logic [XW-1:0]    ram_addr;
    logic             ram_we;
    rgbc_pkg::pixel_t older_rd, newer_rd, up1, up2;

    assign ram_addr = in_acc ? c_now : c_reg;
    assign ram_we   = (state_reg == ST_READ);
    assign up1      = (r_reg >= YW'(1)) ? newer_rd : '0;
    assign up2      = (r_reg >= YW'(2)) ? older_rd : '0;

    rgbc_ram #(.WIDTH(rgbc_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .aclk(aclk), .addr(ram_addr), .we(ram_we), .wdata(up1),
        .re(in_acc), .rdata(older_rd)
    );

    rgbc_ram #(.WIDTH(rgbc_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
        .aclk(aclk), .addr(ram_addr), .we(ram_we), .wdata(pix_reg),
        .re(in_acc), .rdata(newer_rd)
    );

    // window: chain of three column cells, cell 2 takes the newest column
    rgbc_pkg::col_t win [3];
    rgbc_pkg::col_t new_col;

    assign new_col = {pix_reg, up1, up2};

    rgbc_cell u_cell2 (.aclk(aclk), .aresetn(aresetn), .shift(ram_we),
                       .col_in(new_col), .col_out(win[2]));
    rgbc_cell u_cell1 (.aclk(aclk), .aresetn(aresetn), .shift(ram_we),
                       .col_in(win[2]), .col_out(win[1]));
    rgbc_cell u_cell0 (.aclk(aclk), .aresetn(aresetn), .shift(ram_we),
                       .col_in(win[1]), .col_out(win[0]));

    // result list of the current item
    logic [XW-1:0] xs_reg [2];
    logic [YW-1:0] ys_reg [2];
    logic [1:0]    nx_reg, ny_reg;
    logic          ix_reg, iy_reg;
    logic [XW-1:0] x_cur;
    logic [YW-1:0] y_cur;

    assign x_cur = xs_reg[ix_reg];
    assign y_cur = ys_reg[iy_reg];

    // tap selection with border replication
    logic [1:0]    ky_reg, kx_reg;
    logic [YW:0]   yk, yv;
    logic [XW:0]   xk, xv;
    logic [YW-1:0] ry;
    logic [XW-1:0] cx;
    logic [1:0]    wrow, wcol, srow, scol;
    rgbc_pkg::pixel_t tap_pix, src_pix;
    logic [3:0]    kidx;

    always_comb begin
        yk = (YW+1)'(y_cur) + (YW+1)'(ky_reg);
        yv = yk - 1'b1;
        if (yk == '0) begin
            ry = '0;
        end else if (yv > {1'b0, hm1}) begin
            ry = hm1;
        end else begin
            ry = YW'(yv);
        end
        xk = (XW+1)'(x_cur) + (XW+1)'(kx_reg);
        xv = xk - 1'b1;
        if (xk == '0) begin
            cx = '0;
        end else if (xv > {1'b0, wm1}) begin
            cx = wm1;
        end else begin
            cx = XW'(xv);
        end
        wrow    = 2'd2 - 2'(r_reg - ry);
        wcol    = 2'd2 - 2'(c_reg - cx);
        srow    = 2'd2 - 2'(r_reg - y_cur);
        scol    = 2'd2 - 2'(c_reg - x_cur);
        tap_pix = win[wcol][wrow];
        src_pix = win[scol][srow];
        kidx    = 4'(ky_reg) * 4'd3 + 4'(kx_reg);
    end

    // per channel multiply-accumulate
    logic signed [AW-1:0]   acc_reg [4];
    logic signed [CB+8:0]   prod [4];
    logic [AW-1:0]          mag [4];
    logic [NW-1:0]          div_num [4];
    logic [NW-1:0]          div_quo [4];
    logic [3:0]             div_busy;
    logic [15:0]            dmag;
    logic                   div_on;
    logic                   div_start;
    logic [7:0]             res [4];

    assign div_on    = (divisor_reg != 16'sd0) && (divisor_reg != rgbc_pkg::DIV_UNITY);
    assign dmag      = divisor_reg[15] ? 16'(-divisor_reg) : 16'(divisor_reg);
    assign div_start = (state_reg == ST_SCALE) && div_on;

    for (genvar ch = 0; ch < 4; ch++) begin : g_ch
        assign prod[ch] = coef[kidx] * $signed({1'b0, tap_pix[8*ch +: 8]});
        assign mag[ch]  = acc_reg[ch][AW-1] ? AW'(-acc_reg[ch]) : AW'(acc_reg[ch]);
        assign div_num[ch] = (NW'(mag[ch]) << 9) + NW'(dmag);

        rgbc_div #(.NW(NW), .DW(DW)) u_div (
            .aclk(aclk), .aresetn(aresetn), .start(div_start),
            .num(div_num[ch]), .den({dmag, 1'b0}),
            .busy(div_busy[ch]), .quo(div_quo[ch])
        );

        always_comb begin
            if (!mask_reg[ch]) begin
                res[ch] = src_pix[8*ch +: 8];
            end else if (div_on) begin
                // a negative quotient saturates to zero
                if (acc_reg[ch][AW-1] != divisor_reg[15]) begin
                    res[ch] = 8'd0;
                end else if (div_quo[ch] > NW'(255)) begin
                    res[ch] = 8'd255;
                end else begin
                    res[ch] = div_quo[ch][7:0];
                end
            end else if (acc_reg[ch][AW-1]) begin
                res[ch] = 8'd0;
            end else if (acc_reg[ch] > AW'(255)) begin
                res[ch] = 8'd255;
            end else begin
                res[ch] = acc_reg[ch][7:0];
            end
        end
    end

    logic last_res;
    assign last_res = (ix_reg == nx_reg[1]) && (iy_reg == ny_reg[1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            m_tvalid    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        pix_reg   <= s_tdata;
                        c_reg     <= c_now;
                        r_reg     <= r_now;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (c_reg == wm1) begin
                        col_cnt_reg <= '0;
                        row_cnt_reg <= (r_reg == hm1) ? '0 : r_reg + 1'b1;
                    end else begin
                        col_cnt_reg <= c_reg + 1'b1;
                        row_cnt_reg <= r_reg;
                    end
                    if (c_reg != '0) begin
                        xs_reg[0] <= c_reg - 1'b1;
                        xs_reg[1] <= c_reg;
                        nx_reg    <= (c_reg == wm1) ? 2'd2 : 2'd1;
                    end else begin
                        xs_reg[0] <= c_reg;
                        xs_reg[1] <= c_reg;
                        nx_reg    <= (c_reg == wm1) ? 2'd1 : 2'd0;
                    end
                    if (r_reg != '0) begin
                        ys_reg[0] <= r_reg - 1'b1;
                        ys_reg[1] <= r_reg;
                        ny_reg    <= (r_reg == hm1) ? 2'd2 : 2'd1;
                    end else begin
                        ys_reg[0] <= r_reg;
                        ys_reg[1] <= r_reg;
                        ny_reg    <= (r_reg == hm1) ? 2'd1 : 2'd0;
                    end
                    ix_reg <= 1'b0;
                    iy_reg <= 1'b0;
                    ky_reg <= 2'd0;
                    kx_reg <= 2'd0;
                    // no result when either list is empty
                    if (c_reg == '0 && c_reg != wm1) begin
                        state_reg <= ST_IDLE;
                    end else if (r_reg == '0 && r_reg != hm1) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    for (int ch = 0; ch < 4; ch++) begin
                        if (ky_reg == 2'd0 && kx_reg == 2'd0) begin
                            acc_reg[ch] <= AW'(prod[ch]);
                        end else begin
                            acc_reg[ch] <= acc_reg[ch] + AW'(prod[ch]);
                        end
                    end
                    if (kx_reg == 2'd2) begin
                        kx_reg <= 2'd0;
                        if (ky_reg == 2'd2) begin
                            ky_reg    <= 2'd0;
                            state_reg <= ST_SCALE;
                        end else begin
                            ky_reg <= ky_reg + 1'b1;
                        end
                    end else begin
                        kx_reg <= kx_reg + 1'b1;
                    end
                end
                ST_SCALE, ST_DIV: begin
                    if (state_reg == ST_SCALE && div_on) begin
                        state_reg <= ST_DIV;
                    end else if (div_busy == '0) begin
                        m_tdata   <= {2'b00, 11'(y_cur), 11'(x_cur),
                                      res[3], res[2], res[1], res[0]};
                        m_tlast   <= last_res;
                        m_tuser   <= (x_cur == wm1) && (y_cur == hm1);
                        m_tvalid  <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        m_tvalid <= 1'b0;
                        if (last_res) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            // advance columns inner, rows outer
                            if (ix_reg == nx_reg[1]) begin
                                ix_reg <= 1'b0;
                                iy_reg <= 1'b1;
                            end else begin
                                ix_reg <= 1'b1;
                            end
                            state_reg <= ST_MAC;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `RGBC_ASSERT_SAME(a_no_overlap, m_tvalid, !s_tready, "input taken while a result waits")
    `RGBC_ASSERT_NEXT(a_one_item, in_acc, !s_tready, "second item taken before the first finished")
    `RGBC_ASSERT_SAME(a_frame_last, m_tvalid && m_tuser, m_tlast, "frame end not last of run")
    `RGBC_ASSERT_SAME(a_div_idle, m_tvalid, div_busy == '0, "result shown while divider runs")

endmodule
